@@ rtl/cla_pkg.sv @@
// Shared types, constants and helper functions of the look-at camera matrix block.
`default_nettype none
package cla_pkg;

	// fixed point format
	localparam int FRAC_BITS = 16;
	localparam int AXW       = FRAC_BITS + 2;   // unit axis component
	localparam int VDW       = 35;              // negated view dot product
	localparam int VW        = 50;              // vector fed to the normalizer

	localparam logic [63:0] COT_PI8_Q32 = 64'd10368968296;
	localparam logic [63:0] H_FIX =
		(COT_PI8_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	localparam logic [31:0] ONE_FIX  = 32'(64'd1 << FRAC_BITS);
	localparam logic [31:0] MONE_FIX = 32'(-(64'sd1 <<< FRAC_BITS));
	localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	// register indexes
	localparam logic [2:0] REG_UP_X   = 3'd0;
	localparam logic [2:0] REG_UP_Y   = 3'd1;
	localparam logic [2:0] REG_UP_Z   = 3'd2;
	localparam logic [2:0] REG_ASPECT = 3'd3;
	localparam logic [2:0] REG_NEAR   = 3'd4;
	localparam logic [2:0] REG_FAR    = 3'd5;

	localparam logic [31:0] RST_UP_X   = 32'd0;
	localparam logic [31:0] RST_UP_Y   = 32'd65536;
	localparam logic [31:0] RST_UP_Z   = 32'd0;
	localparam logic [30:0] RST_ASPECT = 31'd116508;
	localparam logic [30:0] RST_NEAR   = 31'd6554;
	localparam logic [30:0] RST_FAR    = 31'd65536000;

	// matrix ids
	localparam logic [1:0] MID_WORLD = 2'd0;
	localparam logic [1:0] MID_VIEW  = 2'd1;
	localparam logic [1:0] MID_PROJ  = 2'd2;

	typedef struct packed {
		logic signed [31:0] eye_x;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_z;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         matrix_id;
		logic [1:0]         row_index;
		logic signed [31:0] col0;
		logic signed [31:0] col1;
		logic signed [31:0] col2;
		logic signed [31:0] col3;
		logic               last;
		logic               degenerate;
	} out_beat_t;

	typedef struct packed {
		logic signed [31:0] up_x;
		logic signed [31:0] up_y;
		logic signed [31:0] up_z;
		logic [30:0]        aspect;
		logic [30:0]        near_p;
		logic [30:0]        far_p;
	} cfg_t;

	// one queued camera update
	typedef struct packed {
		logic [2:0][31:0] eye;
		logic [2:0][32:0] dv;
		logic             dzero;
	} job_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [31:0] den;
	} div_req_t;

	function automatic logic [1:0] inc3(input logic [1:0] k);
		return (k == 2'd2) ? 2'd0 : k + 2'd1;
	endfunction

	// saturate a magnitude with a sign to 32 bits
	function automatic logic [31:0] sat_mag(input logic [63:0] q, input logic neg);
		logic [31:0] r;
		if (!neg) begin
			r = (q > 64'h7FFF_FFFF) ? SAT_MAX : q[31:0];
		end else begin
			r = (q > 64'h8000_0000) ? SAT_MIN : 32'(-q[31:0]);
		end
		return r;
	endfunction

	function automatic logic [31:0] sat_s64(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sh7FFF_FFFF) r = SAT_MAX;
		else if (v < -64'sh8000_0000) r = SAT_MIN;
		else r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/cla_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module cla_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cla_pkg::div_req_t req,
	output logic                   done,
	output logic [63:0]            quo
);
	import cla_pkg::*;

	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic        fits;

	// shift in the next numerator bit and try a subtract
	assign rem_sh = {rem_q, quo_q[63]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

@@ rtl/cla_fifo.sv @@
// Two-entry queue between the front and the back.
`default_nettype none
module cla_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cla_pkg::job_t push_data,
	output logic               full,
	input  wire logic          pop,
	output cla_pkg::job_t      pop_data,
	output logic               empty
);
	import cla_pkg::*;

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

@@ rtl/cla_front.sv @@
// Front end: accepts camera beats, forms eye minus target and flags a zero view vector.
`default_nettype none
module cla_front (
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire cla_pkg::in_beat_t in_data,
	input  wire logic              q_full,
	output logic                   q_push,
	output cla_pkg::job_t          q_data
);
	import cla_pkg::*;

	logic signed [32:0] dx, dy, dz;

	assign dx = 33'(in_data.eye_x) - 33'(in_data.target_x);
	assign dy = 33'(in_data.eye_y) - 33'(in_data.target_y);
	assign dz = 33'(in_data.eye_z) - 33'(in_data.target_z);

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_data.eye[0] = in_data.eye_x;
		q_data.eye[1] = in_data.eye_y;
		q_data.eye[2] = in_data.eye_z;
		q_data.dv[0]  = dx;
		q_data.dv[1]  = dy;
		q_data.dv[2]  = dz;
		q_data.dzero  = (dx == '0) && (dy == '0) && (dz == '0);
	end

endmodule
`default_nettype wire

@@ rtl/cla_back.sv @@
// Back end: sequencer with shared multiplier, square root and divider; emits the rows.
`default_nettype none
module cla_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cla_pkg::cfg_t  cfg,
	input  wire logic           q_empty,
	input  wire cla_pkg::job_t  q_data,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output cla_pkg::out_beat_t  out_data
);
	import cla_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ABS   = 4'd1;
	localparam logic [3:0] ST_SHIFT = 4'd2;
	localparam logic [3:0] ST_SQ    = 4'd3;
	localparam logic [3:0] ST_SQRT  = 4'd4;
	localparam logic [3:0] ST_NDIV  = 4'd5;
	localparam logic [3:0] ST_NEXT  = 4'd6;
	localparam logic [3:0] ST_MAC   = 4'd7;
	localparam logic [3:0] ST_PDIV  = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;

	localparam logic PH_Z = 1'b0;
	localparam logic PH_X = 1'b1;

	localparam logic [1:0] MP_C = 2'd0;
	localparam logic [1:0] MP_Y = 2'd1;
	localparam logic [1:0] MP_D = 2'd2;
	localparam logic [1:0] MP_N = 2'd3;

	// control
	logic [3:0] state_q;
	logic       ph_q;
	logic [1:0] mp_q;
	logic [1:0] k_q;
	logic [1:0] t_q;
	logic [1:0] dk_q;
	logic       dwait_q;
	logic [3:0] row_q;
	logic       out_valid_q;
	logic       deg_q;

	// datapath
	logic signed [31:0]     eye_q  [3];
	logic signed [VW-1:0]   vec_q  [3];
	logic [VW-1:0]          a_q    [3];
	logic [2:0]             neg_q;
	logic signed [63:0]     acc_q;
	logic [63:0]            sum_q;
	logic [63:0]            root_q;
	logic [63:0]            bit_q;
	logic signed [AXW-1:0]  nres_q [3];
	logic signed [AXW-1:0]  z_q    [3];
	logic signed [AXW-1:0]  x_q    [3];
	logic signed [AXW-1:0]  y_q    [3];
	logic signed [VDW-1:0]  vd_q   [3];
	logic [63:0]            fn_q;
	logic [63:0]            pq_q   [3];
	out_beat_t              out_q;

	// shared multiply-accumulate
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic               msub;
	logic signed [63:0] acc_base, acc_next, rnd_sum;
	logic [1:0]         i1, i2, t_last;

	// divider
	div_req_t   dreq;
	logic       div_done;
	logic [63:0] div_quo;

	logic        big, tiny, vzero;
	logic [63:0] trial;
	logic        dz, dneg;
	logic [30:0] ad;
	logic        out_fire, out_load;
	out_beat_t   row_d;

	cla_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (div_done),
		.quo    (div_quo)
	);

	// config derived terms
	assign dz   = cfg.near_p == cfg.far_p;
	assign dneg = cfg.near_p < cfg.far_p;
	assign ad   = dneg ? 31'(cfg.far_p - cfg.near_p) : 31'(cfg.near_p - cfg.far_p);

	// normalizer range checks
	always_comb begin
		big   = 1'b0;
		tiny  = 1'b1;
		vzero = 1'b1;
		for (int i = 0; i < 3; i++) begin
			big   = big | (|a_q[i][VW-1:30]);
			tiny  = tiny & ~(|a_q[i][VW-1:29]);
			vzero = vzero & (vec_q[i] == '0);
		end
	end

	assign trial = root_q + bit_q;

	// multiplier operand select
	assign i1 = inc3(k_q);
	assign i2 = inc3(i1);

	function automatic logic signed [31:0] cfg_up(input logic [1:0] i);
		logic signed [31:0] r;
		unique case (i)
			2'd0:    r = cfg.up_x;
			2'd1:    r = cfg.up_y;
			default: r = cfg.up_z;
		endcase
		return r;
	endfunction

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		msub   = 1'b0;
		t_last = 2'd0;
		if (state_q == ST_SQ) begin
			mul_a = 33'({3'b000, a_q[t_q][29:0]});
			mul_b = 33'({3'b000, a_q[t_q][29:0]});
		end else begin
			unique case (mp_q)
				MP_C: begin
					t_last = 2'd1;
					msub   = t_q[0];
					mul_a  = t_q[0] ? 33'(cfg_up(i2)) : 33'(cfg_up(i1));
					mul_b  = t_q[0] ? 33'(z_q[i1]) : 33'(z_q[i2]);
				end
				MP_Y: begin
					t_last = 2'd1;
					msub   = t_q[0];
					mul_a  = t_q[0] ? 33'(z_q[i2]) : 33'(z_q[i1]);
					mul_b  = t_q[0] ? 33'(x_q[i1]) : 33'(x_q[i2]);
				end
				MP_D: begin
					t_last = 2'd2;
					mul_a  = 33'(eye_q[t_q]);
					unique case (k_q)
						2'd0:    mul_b = 33'(x_q[t_q]);
						2'd1:    mul_b = 33'(y_q[t_q]);
						default: mul_b = 33'(z_q[t_q]);
					endcase
				end
				MP_N: begin
					mul_a = 33'({2'b00, cfg.far_p});
					mul_b = 33'({2'b00, cfg.near_p});
				end
			endcase
		end
	end

	assign prod     = mul_a * mul_b;
	assign acc_base = (t_q == 2'd0) ? 64'sd0 : acc_q;
	assign acc_next = msub ? acc_base - prod[63:0] : acc_base + prod[63:0];
	assign rnd_sum  = (acc_next + RND_HALF) >>> FRAC_BITS;

	// divider operands
	always_comb begin
		dreq.start = ((state_q == ST_NDIV) || (state_q == ST_PDIV)) && !dwait_q;
		dreq.num   = '0;
		dreq.den   = '0;
		if (state_q == ST_NDIV) begin
			dreq.num = (64'(a_q[dk_q][29:0]) << FRAC_BITS) + 64'(root_q[31:1]);
			dreq.den = root_q[31:0];
		end else begin
			unique case (dk_q)
				2'd0: begin
					dreq.num = (H_FIX << FRAC_BITS) + 64'(cfg.aspect[30:1]);
					dreq.den = 32'(cfg.aspect);
				end
				2'd1: begin
					dreq.num = (64'(cfg.far_p) << FRAC_BITS) + 64'(ad[30:1]);
					dreq.den = 32'(ad);
				end
				default: begin
					dreq.num = fn_q + 64'(ad[30:1]);
					dreq.den = 32'(ad);
				end
			endcase
		end
	end

	// row builder
	always_comb begin
		logic [31:0] hv, wv, rv, rnv;
		hv  = dz ? 32'd0 : H_FIX[31:0];
		wv  = dz ? 32'd0 : ((cfg.aspect == '0) ? SAT_MAX : sat_mag(pq_q[0], 1'b0));
		rv  = dz ? 32'd0 : sat_mag(pq_q[1], dneg);
		rnv = dz ? 32'd0 : sat_mag(pq_q[2], dneg);
		row_d.matrix_id  = (row_q < 4'd4) ? MID_WORLD : ((row_q < 4'd8) ? MID_VIEW : MID_PROJ);
		row_d.row_index  = row_q[1:0];
		row_d.last       = row_q == 4'd11;
		row_d.degenerate = deg_q | dz;
		row_d.col0 = '0;
		row_d.col1 = '0;
		row_d.col2 = '0;
		row_d.col3 = '0;
		unique case (row_q)
			4'd0: begin
				row_d.col0 = 32'(x_q[0]); row_d.col1 = 32'(x_q[1]); row_d.col2 = 32'(x_q[2]);
			end
			4'd1: begin
				row_d.col0 = 32'(y_q[0]); row_d.col1 = 32'(y_q[1]); row_d.col2 = 32'(y_q[2]);
			end
			4'd2: begin
				row_d.col0 = 32'(z_q[0]); row_d.col1 = 32'(z_q[1]); row_d.col2 = 32'(z_q[2]);
			end
			4'd3: begin
				row_d.col0 = eye_q[0]; row_d.col1 = eye_q[1]; row_d.col2 = eye_q[2];
				row_d.col3 = ONE_FIX;
			end
			4'd4, 4'd5, 4'd6: begin
				row_d.col0 = 32'(x_q[row_q[1:0]]);
				row_d.col1 = 32'(y_q[row_q[1:0]]);
				row_d.col2 = 32'(z_q[row_q[1:0]]);
			end
			4'd7: begin
				row_d.col0 = sat_s64(64'(vd_q[0]));
				row_d.col1 = sat_s64(64'(vd_q[1]));
				row_d.col2 = sat_s64(64'(vd_q[2]));
				row_d.col3 = ONE_FIX;
			end
			4'd8:  row_d.col0 = wv;
			4'd9:  row_d.col1 = hv;
			4'd10: begin
				row_d.col2 = rv;
				row_d.col3 = MONE_FIX;
			end
			4'd11: row_d.col2 = rnv;
			default: row_d.col0 = '0;
		endcase
	end

	// output register
	assign out_fire  = out_valid_q && !out_stall;
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= PH_Z;
			mp_q        <= MP_C;
			k_q         <= '0;
			t_q         <= '0;
			dk_q        <= '0;
			dwait_q     <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
			deg_q       <= 1'b0;
		end else begin
			// a new row replaces the one leaving in the same cycle
			if (out_load) out_valid_q <= 1'b1;
			else if (out_fire) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						for (int i = 0; i < 3; i++) begin
							eye_q[i] <= q_data.eye[i];
							vec_q[i] <= VW'($signed(q_data.dv[i]));
						end
						deg_q   <= q_data.dzero;
						ph_q    <= PH_Z;
						state_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= vec_q[i][VW-1];
						a_q[i]   <= vec_q[i][VW-1] ? VW'(-vec_q[i]) : VW'(vec_q[i]);
					end
					if (vzero) begin
						for (int i = 0; i < 3; i++) nres_q[i] <= '0;
						deg_q   <= 1'b1;
						state_q <= ST_NEXT;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (big) begin
						for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
					end else if (tiny) begin
						for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
					end else begin
						t_q     <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					acc_q <= acc_next;
					t_q   <= inc3(t_q);
					if (t_q == 2'd2) begin
						sum_q   <= acc_next;
						root_q  <= '0;
						bit_q   <= 64'h4000_0000_0000_0000;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sum_q >= trial) begin
						sum_q  <= sum_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						dk_q    <= '0;
						dwait_q <= 1'b0;
						state_q <= ST_NDIV;
					end
				end
				ST_NDIV: begin
					if (!dwait_q) begin
						dwait_q <= 1'b1;
					end else if (div_done) begin
						nres_q[dk_q] <= neg_q[dk_q] ? AXW'(-div_quo) : AXW'(div_quo);
						dwait_q      <= 1'b0;
						dk_q         <= dk_q + 2'd1;
						if (dk_q == 2'd2) state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					for (int i = 0; i < 3; i++) begin
						if (ph_q == PH_Z) z_q[i] <= nres_q[i];
						else x_q[i] <= nres_q[i];
					end
					mp_q    <= (ph_q == PH_Z) ? MP_C : MP_Y;
					k_q     <= '0;
					t_q     <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					acc_q <= acc_next;
					if (t_q != t_last) begin
						t_q <= t_q + 2'd1;
					end else begin
						t_q <= '0;
						k_q <= inc3(k_q);
						unique case (mp_q)
							MP_C: begin
								vec_q[k_q] <= VW'(acc_next);
								if (k_q == 2'd2) begin
									ph_q    <= PH_X;
									state_q <= ST_ABS;
								end
							end
							MP_Y: begin
								y_q[k_q] <= AXW'(rnd_sum);
								if (k_q == 2'd2) mp_q <= MP_D;
							end
							MP_D: begin
								vd_q[k_q] <= VDW'(-rnd_sum);
								if (k_q == 2'd2) mp_q <= MP_N;
							end
							MP_N: begin
								fn_q    <= acc_next;
								dk_q    <= '0;
								dwait_q <= 1'b0;
								state_q <= ST_PDIV;
							end
						endcase
					end
				end
				ST_PDIV: begin
					if (!dwait_q) begin
						dwait_q <= 1'b1;
					end else if (div_done) begin
						pq_q[dk_q] <= div_quo;
						dwait_q    <= 1'b0;
						dk_q       <= dk_q + 2'd1;
						if (dk_q == 2'd2) begin
							row_q   <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						out_q <= row_d;
						row_q <= row_q + 4'd1;
						if (row_q == 4'd11) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/camera_look_at_matrices.sv @@
// The time from an accepted beat to its first row is set by nine divisions, two square
// roots and the normalizer shift runs; it is shorter when eye equals target, as both
// normalizations are then skipped.
// The back end starts a new camera beat only after loading all twelve rows of the last;
// two more beats are held in the input queue while the back end works.
// Reset: arst_n clears control state at once and loads the register reset values.
`default_nettype none
module camera_look_at_matrices (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire cla_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output cla_pkg::out_beat_t      out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import cla_pkg::*;

	cfg_t cfg_q;
	job_t push_data, pop_data;
	logic push, pop, full, empty;
	logic wr_en;

	// register file
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.up_x   <= RST_UP_X;
			cfg_q.up_y   <= RST_UP_Y;
			cfg_q.up_z   <= RST_UP_Z;
			cfg_q.aspect <= RST_ASPECT;
			cfg_q.near_p <= RST_NEAR;
			cfg_q.far_p  <= RST_FAR;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_UP_X:   cfg_q.up_x   <= pwdata;
				REG_UP_Y:   cfg_q.up_y   <= pwdata;
				REG_UP_Z:   cfg_q.up_z   <= pwdata;
				REG_ASPECT: cfg_q.aspect <= pwdata[30:0];
				REG_NEAR:   cfg_q.near_p <= pwdata[30:0];
				REG_FAR:    cfg_q.far_p  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_UP_X:   prdata = cfg_q.up_x;
			REG_UP_Y:   prdata = cfg_q.up_y;
			REG_UP_Z:   prdata = cfg_q.up_z;
			REG_ASPECT: prdata = {1'b0, cfg_q.aspect};
			REG_NEAR:   prdata = {1'b0, cfg_q.near_p};
			REG_FAR:    prdata = {1'b0, cfg_q.far_p};
			default:    prdata = '0;
		endcase
	end

	cla_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (full),
		.q_push   (push),
		.q_data   (push_data)
	);

	cla_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	cla_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (empty),
		.q_data    (pop_data),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
